// ----- sv/bda_pkg.sv -----
// Shared constants and types for the binary to decimal ASCII converter.
// Used by bda_front, bda_back and binary_to_decimal_ascii_top; no dependencies.
package bda_pkg;

    localparam int FIELD_BITS = 32;
    localparam int VALUE_BITS = 32;
    localparam int CONV_BITS  = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

    // Decimal digits of the largest CONV_BITS-bit value: ceil(CONV_BITS * log10(2)).
    localparam int MAX_DIGITS = (CONV_BITS * 30103 + 99999) / 100000;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
    localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int STEP_W     = $clog2(CONV_BITS + 1);
    localparam int CHAR_W     = 6;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    localparam logic [FIELD_BITS-1:0] VALUE_MASK = (CONV_BITS >= FIELD_BITS) ? '1 :
        FIELD_BITS'((64'd1 << CONV_BITS) - 64'd1);

    // One queued conversion request, classified by the front.
    typedef struct packed {
        logic [CONV_BITS-1:0] value;
        logic                 is_zero;
    } t_job;

endpackage

// ----- sv/binary_to_decimal_ascii_top.sv -----
// Top level of the binary to decimal ASCII converter.
// Instantiates bda_front and bda_back; depends on bda_pkg.
//
// Each accepted request carries a 32-bit unsigned value; the block answers
// with its decimal digits as ASCII characters, most significant first, with
// no leading zeros, and o_last high on the final digit (zero gives one '0').
// A value leaves the two-entry input queue, is converted by shift-and-add-3 in
// the single iterative BCD converter, has its leading digit found, and then
// sends one digit per cycle while the output is not stalled; a zero value
// skips the converter.
// Requests keep being accepted into the queue while the converter is busy, until it is full.
module binary_to_decimal_ascii_top import bda_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [FIELD_BITS-1:0] i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CHAR_W-1:0]     o_digit_char,
    output logic                  o_last
);

    logic job_valid;
    logic job_ready;
    t_job job;

    bda_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    bda_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (job_valid),
        .o_job_ready  (job_ready),
        .i_job        (job),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

endmodule

// ----- sv/bda_front.sv -----
// Front end: accepts requests, masks and classifies the value, and holds
// them in a two-entry queue for the back end. Depends on bda_pkg.
module bda_front import bda_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [FIELD_BITS-1:0] i_value,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output t_job                  o_job
);

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       push;
    logic       pop;
    t_job       w_job;

    logic [FIELD_BITS-1:0] masked;

    assign masked          = i_value & VALUE_MASK;
    assign w_job.value     = masked[CONV_BITS-1:0];
    assign w_job.is_zero   = (masked == '0);

    assign o_in_ready  = (r_count != 2'd2);
    assign o_job_valid = (r_count != 2'd0);
    assign o_job       = r_mem[r_rptr];

    assign push = i_in_valid && o_in_ready;
    assign pop  = o_job_valid && i_job_ready;

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= w_job;
        end
    end

endmodule

// ----- sv/bda_back.sv -----
// Back end: converts one queued value to BCD by shift-and-add-3, then sends
// its digits as ASCII through an output register. Depends on bda_pkg.
module bda_back import bda_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  t_job              i_job,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CHAR_W-1:0] o_digit_char,
    output logic              o_last
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CONV   = 2'd1;
    localparam logic [1:0] ST_LOCATE = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [CONV_BITS-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]     r_bcd, n_bcd;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]    r_char, n_char;
    logic                 r_last, n_last;

    logic [BCD_W-1:0]   adjusted;
    logic [IDX_W-1:0]   lead_idx;
    logic [DIGIT_W-1:0] cur_digit;
    logic               out_free;

    // Add three to every digit of five or more before the next shift.
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (r_bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                adjusted[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                adjusted[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // Position of the most significant nonzero digit; upper digits win.
    always_comb begin
        lead_idx = '0;
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (r_bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
                lead_idx = IDX_W'(d);
            end
        end
    end

    assign cur_digit   = r_bcd[int'(r_idx)*DIGIT_W +: DIGIT_W];
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_job_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_step      = r_step;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_char      = r_char;
        n_last      = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_bin  = i_job.value;
                    n_bcd  = '0;
                    n_step = STEP_W'(CONV_BITS);
                    n_idx  = '0;
                    // A zero value skips the conversion and sends a single '0'.
                    n_state = i_job.is_zero ? ST_EMIT : ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd  = {adjusted[BCD_W-2:0], r_bin[CONV_BITS-1]};
                n_bin  = r_bin << 1;
                n_step = r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    n_state = ST_LOCATE;
                end
            end
            ST_LOCATE: begin
                n_idx   = lead_idx;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = ASCII_ZERO + CHAR_W'(cur_digit);
                    n_last      = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx - IDX_W'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_step <= n_step;
        r_idx  <= n_idx;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_digit_char = r_char;
    assign o_last       = r_last;

endmodule
